FILE: rtl/core/mrsq_pkg.sv
package mrsq_pkg;

    localparam int COL_W    = 10;
    localparam int SAMPLE_W = 24;
    localparam int SHIFT_W  = SAMPLE_W + 1;
    localparam int ABS_W    = SAMPLE_W + 1;
    localparam int DEN_W    = SAMPLE_W + 2;
    localparam int STEP_W   = 31;
    localparam int COORD_W  = 32;
    localparam int NUM_W    = STEP_W + ABS_W;
    localparam int QUO_W    = 32;
    localparam int POS_W    = 45;
    localparam int CFG_IDX_W = 3;
    localparam int GRID_CELLS_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP    = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

    typedef logic [1:0] t_edge;
    localparam t_edge E_TOP    = 2'd0;
    localparam t_edge E_RIGHT  = 2'd1;
    localparam t_edge E_BOTTOM = 2'd2;
    localparam t_edge E_LEFT   = 2'd3;

    // packed {seg1 end, seg1 start, seg0 end, seg0 start}
    localparam logic [7:0] SEG_EDGES [16] = '{
        8'h00,
        {E_TOP, E_TOP, E_TOP, E_LEFT},
        {E_TOP, E_TOP, E_RIGHT, E_TOP},
        {E_TOP, E_TOP, E_RIGHT, E_LEFT},
        {E_TOP, E_TOP, E_BOTTOM, E_RIGHT},
        {E_TOP, E_LEFT, E_BOTTOM, E_RIGHT},
        {E_TOP, E_TOP, E_BOTTOM, E_TOP},
        {E_TOP, E_TOP, E_BOTTOM, E_LEFT},
        {E_TOP, E_TOP, E_LEFT, E_BOTTOM},
        {E_TOP, E_TOP, E_TOP, E_BOTTOM},
        {E_LEFT, E_BOTTOM, E_RIGHT, E_TOP},
        {E_TOP, E_TOP, E_RIGHT, E_BOTTOM},
        {E_TOP, E_TOP, E_LEFT, E_RIGHT},
        {E_TOP, E_TOP, E_TOP, E_RIGHT},
        {E_TOP, E_TOP, E_LEFT, E_TOP},
        8'h00
    };

    localparam logic [1:0] SEG_COUNT [16] = '{
        2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
    };

    typedef struct packed {
        logic [3:0]       code;
        logic [POS_W-1:0] xl;
        logic [POS_W-1:0] xr;
        logic [POS_W-1:0] yb;
        logic [POS_W-1:0] yt;
    } t_side;

endpackage

FILE: rtl/core/mrsq_div.sv
module mrsq_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [mrsq_pkg::NUM_W-1:0]  i_num,
    input  logic [mrsq_pkg::DEN_W-1:0]  i_den,
    output logic [mrsq_pkg::QUO_W-1:0]  o_quo
);

    localparam int QW = mrsq_pkg::QUO_W;
    localparam int DW = mrsq_pkg::DEN_W;
    localparam int NW = mrsq_pkg::NUM_W;

    logic [DW-1:0] w_rem [0:QW];
    logic [QW-1:0] w_low [0:QW];
    logic [QW-1:0] w_quo [0:QW];
    logic [DW-1:0] w_den [0:QW];

    // quotient never exceeds 32 bits, so the high numerator bits seed the remainder
    assign w_rem[0] = {{(DW-(NW-QW)){1'b0}}, i_num[NW-1:QW]};
    assign w_low[0] = i_num[QW-1:0];
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_low;
        logic [QW-1:0] r_quo;
        logic [DW-1:0] r_den;

        always_comb begin
            w_trial = {w_rem[k], w_low[k][QW-1]};
            w_diff  = w_trial - {1'b0, w_den[k]};
            w_ge    = (w_trial >= {1'b0, w_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_low <= {w_low[k][QW-2:0], 1'b0};
                r_quo <= {w_quo[k][QW-2:0], w_ge};
                r_den <= w_den[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_low[k+1] = r_low;
        assign w_quo[k+1] = r_quo;
        assign w_den[k+1] = r_den;
    end

    assign o_quo = w_quo[QW];

endmodule

FILE: rtl/core/marching_squares_cell.sv
// marching-squares cell: one grid cell in, up to two isoline segments out.
// input stream: one request per cell carries column, row and four corner
// samples; a cell whose column or row is GRID_CELLS or more is dropped.
// output stream: one request per segment, tlast on the last one of the cell;
// cells with all corners above or all below the level give nothing.
// config channel: register index and data, always ready; write only while idle.
// path: a cell passes 4 front stages, a 32-stage restoring divider per cell edge
// and the output register before its first segment shows.
// throughput: one cell per cycle while tready stays high; a two-segment cell
// holds the single output register until its second segment is taken.
// stalls: while the receiver holds tready low the pipeline advances only when its
// last slot is empty, so only a bubble there fills; nothing is lost or repeated.
// reset: synchronous active low; clears valid bits and the output state flags
// (not the output data) and sets level 0, origins 0, steps 1.0.
module marching_squares_cell #(
    parameter int GRID_CELLS = mrsq_pkg::GRID_CELLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // cell_col, cell_row, top_left, top_right, bottom_right, bottom_left, pad
    input  logic [119:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // x_start, y_start, x_end, y_end
    output logic [127:0] o_m_tdata,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [mrsq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int SW = mrsq_pkg::SHIFT_W;
    localparam int AW = mrsq_pkg::ABS_W;
    localparam int DW = mrsq_pkg::DEN_W;
    localparam int NW = mrsq_pkg::NUM_W;
    localparam int QW = mrsq_pkg::QUO_W;
    localparam int PW = mrsq_pkg::POS_W;
    localparam int TW = mrsq_pkg::STEP_W;
    localparam int CW = mrsq_pkg::COORD_W;
    localparam int GW = mrsq_pkg::COL_W + TW;

    // configuration
    logic [23:0]   r_iso;
    logic [31:0]   r_x_origin;
    logic [31:0]   r_y_origin;
    logic [TW-1:0] r_x_step;
    logic [TW-1:0] r_y_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso      <= '0;
            r_x_origin <= '0;
            r_y_origin <= '0;
            r_x_step   <= mrsq_pkg::STEP_RESET;
            r_y_step   <= mrsq_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mrsq_pkg::REG_ISO_LEVEL: r_iso      <= i_cfg_data[23:0];
                mrsq_pkg::REG_X_ORIGIN:  r_x_origin <= i_cfg_data;
                mrsq_pkg::REG_Y_ORIGIN:  r_y_origin <= i_cfg_data;
                mrsq_pkg::REG_X_STEP:    r_x_step   <= i_cfg_data[TW-1:0];
                mrsq_pkg::REG_Y_STEP:    r_y_step   <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [9:0]  w_col;
    logic [9:0]  w_row;
    logic [23:0] w_smp [4];
    logic        w_in_grid;

    assign w_col    = i_s_tdata[9:0];
    assign w_row    = i_s_tdata[19:10];
    assign w_smp[0] = i_s_tdata[43:20];
    assign w_smp[1] = i_s_tdata[67:44];
    assign w_smp[2] = i_s_tdata[91:68];
    assign w_smp[3] = i_s_tdata[115:92];
    assign w_in_grid = (32'(w_col) < 32'(GRID_CELLS)) && (32'(w_row) < 32'(GRID_CELLS));

    // pipeline control
    logic r_va, r_vb, r_vc;
    logic r_v [0:QW];
    logic r_ov, r_seg, r_two;
    logic w_done, w_out_free, w_adv, w_load;

    assign w_done     = r_ov && i_m_tready && o_m_tlast;
    assign w_out_free = !r_ov || w_done;
    assign w_adv      = w_out_free || !r_v[QW];
    assign o_s_tready = w_adv;

    // stage a: input register
    logic [9:0]  r_col, r_row;
    logic [23:0] r_smp [4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col <= w_col;
            r_row <= w_row;
            for (int i = 0; i < 4; i++) r_smp[i] <= w_smp[i];
        end
    end

    // stage b: level shift, case code, edge magnitudes, grid products
    logic [SW-1:0] w_s [4];
    logic [SW-1:0] w_v1 [4];
    logic [SW-1:0] w_v0 [4];
    logic [DW-1:0] w_d [4];
    logic [3:0]    n_code;
    logic [AW-1:0] n_abs [4];
    logic [DW-1:0] n_den [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_s[i] = {r_smp[i][23], r_smp[i]} - {r_iso[23], r_iso};
            n_code[i] = !w_s[i][SW-1];
        end
        w_v1[0] = w_s[1]; w_v0[0] = w_s[0];
        w_v1[1] = w_s[1]; w_v0[1] = w_s[2];
        w_v1[2] = w_s[2]; w_v0[2] = w_s[3];
        w_v1[3] = w_s[0]; w_v0[3] = w_s[3];
        for (int e = 0; e < 4; e++) begin
            n_abs[e] = w_v1[e][SW-1] ? -w_v1[e] : w_v1[e];
            w_d[e]   = {w_v1[e][SW-1], w_v1[e]} - {w_v0[e][SW-1], w_v0[e]};
            n_den[e] = w_d[e][DW-1] ? -w_d[e] : w_d[e];
        end
    end

    logic [3:0]    r_code_b;
    logic [AW-1:0] r_abs_b [4];
    logic [DW-1:0] r_den_b [4];
    logic [GW-1:0] r_gx_b, r_gy_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_code_b <= n_code;
            for (int e = 0; e < 4; e++) begin
                r_abs_b[e] <= n_abs[e];
                r_den_b[e] <= n_den[e];
            end
            r_gx_b <= GW'(r_col) * GW'(r_x_step);
            r_gy_b <= GW'(r_row) * GW'(r_y_step);
        end
    end

    // stage c: edge products and grid points
    logic [PW-1:0] n_xl, n_yb;
    logic [NW-1:0] r_prod_c [4];
    logic [DW-1:0] r_den_c [4];
    mrsq_pkg::t_side r_side_c;

    assign n_xl = {{(PW-32){r_x_origin[31]}}, r_x_origin} + PW'(r_gx_b);
    assign n_yb = {{(PW-32){r_y_origin[31]}}, r_y_origin} + PW'(r_gy_b);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod_c[0] <= NW'(r_x_step) * NW'(r_abs_b[0]);
            r_prod_c[1] <= NW'(r_y_step) * NW'(r_abs_b[1]);
            r_prod_c[2] <= NW'(r_x_step) * NW'(r_abs_b[2]);
            r_prod_c[3] <= NW'(r_y_step) * NW'(r_abs_b[3]);
            for (int e = 0; e < 4; e++) r_den_c[e] <= r_den_b[e];
            r_side_c.code <= r_code_b;
            r_side_c.xl   <= n_xl;
            r_side_c.xr   <= n_xl + PW'(r_x_step);
            r_side_c.yb   <= n_yb;
            r_side_c.yt   <= n_yb + PW'(r_y_step);
        end
    end

    // stage d: rounding bias, divider operands
    logic [NW-1:0] r_num_d [4];
    logic [DW-1:0] r_den_d [4];
    mrsq_pkg::t_side r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int e = 0; e < 4; e++) begin
                r_num_d[e] <= r_prod_c[e] + NW'(r_den_c[e] >> 1);
                r_den_d[e] <= r_den_c[e];
            end
        end
    end

    // divider stages with sideband
    logic [QW-1:0] w_quo [4];

    for (genvar e = 0; e < 4; e++) begin : g_edge
        mrsq_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_num_d[e]),
            .i_den (r_den_d[e]),
            .o_quo (w_quo[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r_side_c;
            for (int k = 1; k <= QW; k++) r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            for (int k = 0; k <= QW; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_va   <= i_s_tvalid && w_in_grid;
            r_vb   <= r_va;
            r_vc   <= r_vb;
            r_v[0] <= r_vc;
            for (int k = 1; k <= QW; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage e: crossings, saturation, table lookup
    function automatic logic [CW-1:0] sat32(input logic [PW-1:0] v);
        if (v[PW-1] && !(&v[PW-2:CW-1])) begin
            sat32 = {1'b1, {(CW-1){1'b0}}};
        end else if (!v[PW-1] && (|v[PW-2:CW-1])) begin
            sat32 = {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat32 = v[CW-1:0];
        end
    endfunction

    mrsq_pkg::t_side w_sd;
    logic [CW-1:0]   w_px [4];
    logic [CW-1:0]   w_py [4];
    logic [7:0]      w_edges;
    logic [1:0]      w_cnt;

    always_comb begin
        w_sd    = r_side[QW];
        w_px[0] = sat32(w_sd.xr - PW'(w_quo[0]));
        w_py[0] = sat32(w_sd.yt);
        w_px[1] = sat32(w_sd.xr);
        w_py[1] = sat32(w_sd.yt - PW'(w_quo[1]));
        w_px[2] = sat32(w_sd.xr - PW'(w_quo[2]));
        w_py[2] = sat32(w_sd.yb);
        w_px[3] = sat32(w_sd.xl);
        w_py[3] = sat32(w_sd.yt - PW'(w_quo[3]));
        w_edges = mrsq_pkg::SEG_EDGES[w_sd.code];
        w_cnt   = mrsq_pkg::SEG_COUNT[w_sd.code];
    end

    assign w_load = w_adv && r_v[QW] && (w_cnt != 2'd0);

    // output register
    logic [4*CW-1:0] r_seg0, r_seg1;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_seg0 <= {w_py[w_edges[3:2]], w_px[w_edges[3:2]],
                       w_py[w_edges[1:0]], w_px[w_edges[1:0]]};
            r_seg1 <= {w_py[w_edges[7:6]], w_px[w_edges[7:6]],
                       w_py[w_edges[5:4]], w_px[w_edges[5:4]]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_seg <= 1'b0;
            r_two <= 1'b0;
        end else if (w_load) begin
            r_ov  <= 1'b1;
            r_seg <= 1'b0;
            r_two <= (w_cnt == 2'd2);
        end else if (w_done) begin
            r_ov  <= 1'b0;
            r_seg <= 1'b0;
        end else if (r_ov && i_m_tready) begin
            r_seg <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = !r_two || r_seg;
    assign o_m_tdata  = r_seg ? r_seg1 : r_seg0;

    // checks
    a_seg_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg |-> (r_two && r_ov))
        else $error("second segment shown for a single-segment cell");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> (o_m_tvalid && o_m_tlast))
        else $error("first segment taken without its partner");

    a_off_grid_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !w_in_grid) |=> !r_va)
        else $error("off-grid cell entered the pipeline");

    a_stall_holds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[QW] && r_ov && !i_m_tready) |=> r_v[QW])
        else $error("finished cell lost while output stalled");

endmodule
